// ===== hw/rtl/ray_triangle_hit_test_assert.svh =====
// assertion macros for the ray triangle hit test
`ifndef RAY_TRIANGLE_HIT_TEST_ASSERT_SVH
`define RAY_TRIANGLE_HIT_TEST_ASSERT_SVH

// same-cycle implication, checked on clk, off while rst_n is low
`define RTHT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked on clk, off while rst_n is low
`define RTHT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/rtht_pkg.sv =====
// types, widths and helpers shared by the ray triangle hit test
`timescale 1ns / 1ps
`default_nettype none
package rtht_pkg;

  localparam int COORD_BITS = 24;
  localparam int TOL_W      = 41;
  localparam int DW         = COORD_BITS + 1;   // coordinate difference
  localparam int PW         = 2 * DW;           // product of two differences
  localparam int CW         = PW + 1;           // cross product component
  localparam int LO_W       = (CW + 1) / 2;     // unsigned low slice of a cross term
  localparam int HI_W       = CW - LO_W;        // signed high slice
  localparam int PLO_W      = DW + LO_W + 1;
  localparam int PHI_W      = DW + HI_W;
  localparam int PROD_W     = DW + CW;          // full difference x cross product
  localparam int DOT_W      = PROD_W + 2;       // sum of three
  localparam int EXT_W      = DOT_W + 1;        // room for the final sums
  localparam int CFG_W      = (COORD_BITS > TOL_W) ? COORD_BITS : TOL_W;
  localparam int CFG_IDX_W  = 3;
  localparam int PIPE_LAT   = 8;                // accept to result strobe
  localparam int STG7_BIT   = 6;                // valid bit of the last compute stage

  localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(1678);

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [DW-1:0]         dval_t;
  typedef logic signed [CW-1:0]         cval_t;
  typedef logic signed [DOT_W-1:0]      dot_t;
  typedef logic signed [EXT_W-1:0]      ext_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } pvec_t;

  typedef struct packed {
    dval_t x;
    dval_t y;
    dval_t z;
  } dvec_t;

  typedef struct packed {
    cval_t x;
    cval_t y;
    cval_t z;
  } cvec_t;

  typedef enum logic [2:0] {
    OC_HIT    = 3'd0,
    OC_BEHIND = 3'd1,
    OC_SHORT  = 3'd2,
    OC_U_OUT  = 3'd3,
    OC_V_OUT  = 3'd4
  } outcome_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_START_X = 3'd0,
    CFG_START_Y = 3'd1,
    CFG_START_Z = 3'd2,
    CFG_END_X   = 3'd3,
    CFG_END_Y   = 3'd4,
    CFG_END_Z   = 3'd5,
    CFG_TOL     = 3'd6
  } cfg_idx_t;

  typedef struct packed {
    coord_t corner_a_x;
    coord_t corner_a_y;
    coord_t corner_a_z;
    coord_t corner_b_x;
    coord_t corner_b_y;
    coord_t corner_b_z;
    coord_t corner_c_x;
    coord_t corner_c_y;
    coord_t corner_c_z;
  } in_item_t;

  typedef struct packed {
    logic     hit;
    outcome_t outcome;
  } out_item_t;

  function automatic dval_t ext_d(input coord_t c);
    return {c[COORD_BITS-1], c};
  endfunction

  // exact p - q, one bit wider
  function automatic dvec_t vdiff(input pvec_t p, input pvec_t q);
    dvec_t r;
    r.x = ext_d(p.x) - ext_d(q.x);
    r.y = ext_d(p.y) - ext_d(q.y);
    r.z = ext_d(p.z) - ext_d(q.z);
    return r;
  endfunction

  function automatic ext_t ext_dot(input dot_t v);
    return {v[DOT_W-1], v};
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/ray_triangle_hit_test.sv =====
// top level of the ray segment versus triangle hit test pipeline
`timescale 1ns / 1ps
`default_nettype none
// Tests one triangle per transaction against the ray segment held in the
// configuration registers (start point, end point, edge tolerance).
// Input channel: a transaction is taken at a rising edge with start high
// and busy low; in_data carries the three corners. busy is high only
// during reset and the first cycle after it, so one triangle can enter
// every clock cycle.
// Result channel: out_valid strobes for one cycle with out_data (hit and
// outcome code). The receiver cannot stall; results leave in order.
// Pipeline: eight register stages, the first loaded by the accepting edge;
// out_valid and the result come from the last; the depth is set by the
// difference stage, the two-stage cross product unit, the three-stage sliced
// dot product unit, one sum stage and the compare and output stage.
// Throughput is one triangle per cycle.
// Configuration: cfg_we writes register cfg_idx (0..2 start xyz, 3..5 end
// xyz, 6 tolerance) at once; the user writes only while no transaction is
// in flight (not enforced by the block). Reset (synchronous, rst_n low)
// clears pipeline valid bits, zeroes the coordinates, sets tolerance 1678.
module ray_triangle_hit_test
  import rtht_pkg::*;
(
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   start,
  output logic                  busy,
  input  in_item_t              in_data,
  output logic                  out_valid,
  output out_item_t             out_data,
  input  wire                   cfg_we,
  input  wire [CFG_IDX_W-1:0]   cfg_idx,
  input  wire [CFG_W-1:0]       cfg_wdata
);

  // configuration registers
  pvec_t             start_r, start_nxt;
  pvec_t             end_r, end_nxt;
  logic [TOL_W-1:0]  tol_r, tol_nxt;

  // handshake and valid chain, one bit per register stage
  logic                busy_r;
  logic                in_acc;
  logic [PIPE_LAT-1:0] vld_r, vld_nxt;

  // stage 1: differences
  pvec_t corner_a, corner_b, corner_c;
  dvec_t t_r, d_r, e1_r, e2_r;
  // stages 2 and 3: t and d ride along with the cross products
  dvec_t t2_r, d2_r, t3_r, d3_r;
  cvec_t n_c, p_c, q_c;
  // stage 6: dot products
  dot_t  tn_c, dn_c, u_c, v_c;
  // stage 7: sums and magnitude
  logic  tn_neg_r;
  ext_t  ean_r, det_r, u_r, v_r, uv_r;
  // stage 8: compare
  ext_t      eps_e, neg_eps, lim;
  logic      ean_pos;
  outcome_t  oc;
  out_item_t out_nxt, out_data_r;

  assign in_acc = start && !busy_r;

  // ---------------------------------------------------------------
  // configuration write port
  // ---------------------------------------------------------------
  always_comb begin
    start_nxt = start_r;
    end_nxt   = end_r;
    tol_nxt   = tol_r;
    if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_idx))
        CFG_START_X: start_nxt.x = cfg_wdata[COORD_BITS-1:0];
        CFG_START_Y: start_nxt.y = cfg_wdata[COORD_BITS-1:0];
        CFG_START_Z: start_nxt.z = cfg_wdata[COORD_BITS-1:0];
        CFG_END_X:   end_nxt.x   = cfg_wdata[COORD_BITS-1:0];
        CFG_END_Y:   end_nxt.y   = cfg_wdata[COORD_BITS-1:0];
        CFG_END_Z:   end_nxt.z   = cfg_wdata[COORD_BITS-1:0];
        CFG_TOL:     tol_nxt     = cfg_wdata[TOL_W-1:0];
        default:     ;  // index beyond the list, write dropped
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= '0;
      end_r   <= '0;
      tol_r   <= TOL_RESET;
    end else begin
      start_r <= start_nxt;
      end_r   <= end_nxt;
      tol_r   <= tol_nxt;
    end
  end

  // ---------------------------------------------------------------
  // control: busy out of reset, valid bits travel with the data
  // ---------------------------------------------------------------
  assign vld_nxt = {vld_r[PIPE_LAT-2:0], in_acc};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
      vld_r  <= '0;
    end else begin
      busy_r <= 1'b0;
      vld_r  <= vld_nxt;
    end
  end

  assign busy = busy_r;

  // ---------------------------------------------------------------
  // stage 1: edges, start offset and segment direction
  // ---------------------------------------------------------------
  assign corner_a = '{x: in_data.corner_a_x, y: in_data.corner_a_y, z: in_data.corner_a_z};
  assign corner_b = '{x: in_data.corner_b_x, y: in_data.corner_b_y, z: in_data.corner_b_z};
  assign corner_c = '{x: in_data.corner_c_x, y: in_data.corner_c_y, z: in_data.corner_c_z};

  always_ff @(posedge clk) begin
    e1_r <= vdiff(corner_b, corner_a);
    e2_r <= vdiff(corner_c, corner_a);
    t_r  <= vdiff(start_r, corner_a);
    d_r  <= vdiff(end_r, start_r);
  end

  // ---------------------------------------------------------------
  // stages 2-3: normal n = e1 x e2, p = d x e2, q = t x e1
  // ---------------------------------------------------------------
  rtht_cross u_cross_n (.clk(clk), .a(e1_r), .b(e2_r), .c(n_c));
  rtht_cross u_cross_p (.clk(clk), .a(d_r),  .b(e2_r), .c(p_c));
  rtht_cross u_cross_q (.clk(clk), .a(t_r),  .b(e1_r), .c(q_c));

  always_ff @(posedge clk) begin
    t2_r <= t_r;
    d2_r <= d_r;
    t3_r <= t2_r;
    d3_r <= d2_r;
  end

  // ---------------------------------------------------------------
  // stages 4-6: the four dot products
  // det = e1 . (d x e2) = -(d . n), and (end - a) . n = t . n + d . n,
  // so t.n and d.n cover both plane tests and the determinant
  // ---------------------------------------------------------------
  rtht_dot u_dot_tn (.clk(clk), .a(t3_r), .b(n_c), .dot(tn_c));
  rtht_dot u_dot_dn (.clk(clk), .a(d3_r), .b(n_c), .dot(dn_c));
  rtht_dot u_dot_u  (.clk(clk), .a(t3_r), .b(p_c), .dot(u_c));
  rtht_dot u_dot_v  (.clk(clk), .a(d3_r), .b(q_c), .dot(v_c));

  // ---------------------------------------------------------------
  // stage 7: end plane value, |det|, u + v
  // ---------------------------------------------------------------
  always_ff @(posedge clk) begin
    tn_neg_r <= tn_c[DOT_W-1];
    ean_r    <= ext_dot(tn_c) + ext_dot(dn_c);
    det_r    <= dn_c[DOT_W-1] ? -ext_dot(dn_c) : ext_dot(dn_c);
    u_r      <= ext_dot(u_c);
    v_r      <= ext_dot(v_c);
    uv_r     <= ext_dot(u_c) + ext_dot(v_c);
  end

  // ---------------------------------------------------------------
  // stage 8: bound compares in priority order, registered result
  // ---------------------------------------------------------------
  always_comb begin
    eps_e   = {{(EXT_W-TOL_W){1'b0}}, tol_r};
    neg_eps = -eps_e;
    lim     = det_r + eps_e;
    ean_pos = !ean_r[EXT_W-1] && (ean_r != '0);
    if (tn_neg_r) begin
      oc = OC_BEHIND;
    end else if (ean_pos) begin
      oc = OC_SHORT;
    end else if ((u_r < neg_eps) || (lim < u_r)) begin
      oc = OC_U_OUT;
    end else if ((v_r < neg_eps) || (lim < uv_r)) begin
      oc = OC_V_OUT;
    end else begin
      oc = OC_HIT;
    end
    out_nxt.hit     = (oc == OC_HIT);
    out_nxt.outcome = oc;
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_nxt;
  end

  assign out_valid = vld_r[PIPE_LAT-1];
  assign out_data  = out_data_r;

  // ---------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------
  `include "ray_triangle_hit_test_assert.svh"

  `RTHT_ASSERT_IMP(a_strobe_has_txn, out_valid, $past(in_acc, PIPE_LAT), "result without transaction")
  `RTHT_ASSERT_IMP(a_hit_matches_code, out_valid, out_data.hit == (out_data.outcome == OC_HIT), "hit and outcome disagree")
  `RTHT_ASSERT_IMP(a_det_nonneg, vld_r[STG7_BIT], !det_r[EXT_W-1], "determinant magnitude negative")
  `RTHT_ASSERT_NXT(a_accept_enters, in_acc, vld_r[0], "accepted transaction not in pipeline")

endmodule
`default_nettype wire

// ===== hw/rtl/rtht_cross.sv =====
// two-stage pipelined exact cross product of two difference vectors
`timescale 1ns / 1ps
`default_nettype none
module rtht_cross
  import rtht_pkg::*;
(
  input  wire   clk,
  input  dvec_t a,
  input  dvec_t b,
  output cvec_t c
);

  logic signed [PW-1:0] prod_r [6];
  cvec_t                c_r;

  // stage a: six products
  always_ff @(posedge clk) begin
    prod_r[0] <= a.y * b.z;
    prod_r[1] <= a.z * b.y;
    prod_r[2] <= a.z * b.x;
    prod_r[3] <= a.x * b.z;
    prod_r[4] <= a.x * b.y;
    prod_r[5] <= a.y * b.x;
  end

  // stage b: pairwise differences, exact in one extra bit
  always_ff @(posedge clk) begin
    c_r.x <= {prod_r[0][PW-1], prod_r[0]} - {prod_r[1][PW-1], prod_r[1]};
    c_r.y <= {prod_r[2][PW-1], prod_r[2]} - {prod_r[3][PW-1], prod_r[3]};
    c_r.z <= {prod_r[4][PW-1], prod_r[4]} - {prod_r[5][PW-1], prod_r[5]};
  end

  assign c = c_r;

endmodule
`default_nettype wire

// ===== hw/rtl/rtht_dot.sv =====
// three-stage pipelined exact dot product, difference vector by cross vector
`timescale 1ns / 1ps
`default_nettype none
module rtht_dot
  import rtht_pkg::*;
(
  input  wire   clk,
  input  dvec_t a,
  input  cvec_t b,
  output dot_t  dot
);

  dval_t                   av [3];
  cval_t                   bv [3];
  logic signed [PLO_W-1:0] plo_r  [3];
  logic signed [PHI_W-1:0] phi_r  [3];
  logic [PROD_W-1:0]       comp_r [3];
  dot_t                    dot_r;

  assign av[0] = a.x;
  assign av[1] = a.y;
  assign av[2] = a.z;
  assign bv[0] = b.x;
  assign bv[1] = b.y;
  assign bv[2] = b.z;

  // stage a: split each wide term into signed high and unsigned low slices
  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      plo_r[k] <= av[k] * $signed({1'b0, bv[k][LO_W-1:0]});
      phi_r[k] <= av[k] * $signed(bv[k][CW-1:LO_W]);
    end
  end

  // stage b: rejoin the slices per component
  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      comp_r[k] <= {phi_r[k], {LO_W{1'b0}}}
                 + {{(PROD_W-PLO_W){plo_r[k][PLO_W-1]}}, plo_r[k]};
    end
  end

  // stage c: sum of the three components
  always_ff @(posedge clk) begin
    dot_r <= {{2{comp_r[0][PROD_W-1]}}, comp_r[0]}
           + {{2{comp_r[1][PROD_W-1]}}, comp_r[1]}
           + {{2{comp_r[2][PROD_W-1]}}, comp_r[2]};
  end

  assign dot = dot_r;

endmodule
`default_nettype wire
